>>> rtl/mklp_pkg.sv
// Shared types and constants of the multi-key long press classifier.
package mklp_pkg;

  // Table geometry.
  localparam int SLOT_COUNT = 12;
  localparam int CODE_BITS  = 16;
  localparam int HOLD_BITS  = 16;
  localparam int IDX_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Register map.
  localparam int  APB_ADDR_BITS   = 3;
  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic [HOLD_BITS-1:0] LONG_TICKS_RESET = HOLD_BITS'(500);

  // Input operation codes.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_LONG    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // State of one key slot.
  typedef struct packed {
    logic [CODE_BITS-1:0] key;
    phase_t               phase;
    logic [HOLD_BITS-1:0] hold;
  } slot_t;

  // Command that the head unit applies to the slot passing by.
  typedef struct packed {
    logic                 op;
    logic [CODE_BITS-1:0] code;
    logic                 down;
    logic                 armed;
    logic [HOLD_BITS-1:0] ticks;
  } cmd_t;

  // What the head unit reports for the slot passing by.
  typedef struct packed {
    logic valid;
    logic kind;
    logic hit;
  } head_res_t;

endpackage

>>> rtl/multi_key_long_press_classifier.sv
// Top level of the multi-key short and long press classifier.
//
// The input channel takes one word per key event or per one-tick time step; the
// result channel gives classified presses (key code, short or long, last flag).
// Both channels use valid and ready. The hold time is set through the APB port,
// register long_press_ticks at byte address 0, reset value 500.
//
// The key table is a ring of SLOT_COUNT cells. Each accepted word walks the
// ring once, one slot per cycle through the head unit unless a pending result
// stalls it, so a word is accepted in idle, walks all SLOT_COUNT slots and then
// passes the flush state. The ring walk sets the word rate.
// Results come out in slot order; the last one of a word carries out_last, so
// each result is held in a pending register until the next is known.
// When the receiver stalls while a result is pending, the walk pauses on its
// next step and resumes once the output register empties; the input is not
// taken until the word's walk and flush are done. Synchronous reset frees all
// slots and empties the output; no clearing pass is needed.
module multi_key_long_press_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [mklp_pkg::CODE_BITS-1:0] in_key_code,
  input  logic                           in_key_down,
  input  logic                           in_key_mapped,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mklp_pkg::CODE_BITS-1:0] out_event_key,
  output logic                           out_event_kind,
  output logic                           out_last,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mklp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import mklp_pkg::*;

  state_t state_r, state_nxt;
  logic [IDX_BITS-1:0]  cnt_r, cnt_nxt;
  logic [HOLD_BITS-1:0] ticks_r;
  cmd_t                 cmd_r;
  logic                 done_r;
  logic                 pend_valid_r;
  logic [CODE_BITS-1:0] pend_key_r;
  logic                 pend_kind_r;
  logic                 out_valid_r;
  logic [CODE_BITS-1:0] out_key_r;
  logic                 out_kind_r;
  logic                 out_last_r;

  slot_t     ring_q [SLOT_COUNT];
  slot_t     head_new;
  cmd_t      head_cmd;
  head_res_t head_res;

  logic in_fire;
  logic out_free;
  logic step;
  logic walk_end;
  logic flush_go;
  logic reg_sel;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_LONG_PRESS);
  assign prdata  = reg_sel ? {{(32-HOLD_BITS){1'b0}}, ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= LONG_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      ticks_r <= pwdata[HOLD_BITS-1:0];
    end
  end

  // Handshake and walk control.
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign step     = (state_r == ST_WALK) && (!pend_valid_r || out_free);
  assign walk_end = step && (cnt_r == IDX_BITS'(SLOT_COUNT - 1));
  assign flush_go = (state_r == ST_FLUSH) && (!pend_valid_r || out_free);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) begin
        state_nxt = ST_WALK;
      end
      ST_WALK:  if (walk_end) begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: if (flush_go) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    cnt_nxt  = cnt_r;
    if (in_fire) begin
      cnt_nxt = '0;
    end else if (step) begin
      cnt_nxt = cnt_r + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Capture the command of an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= '0;
      done_r <= 1'b0;
    end else if (in_fire) begin
      cmd_r.op    <= in_operation;
      cmd_r.code  <= in_key_code;
      cmd_r.down  <= in_key_down;
      cmd_r.armed <= (in_operation == OP_KEY) && in_key_mapped && (in_key_code != '0);
      cmd_r.ticks <= '0;
      done_r      <= 1'b0;
    end else if (step && head_res.hit) begin
      done_r <= 1'b1;
    end
  end

  always_comb begin
    head_cmd       = cmd_r;
    head_cmd.armed = cmd_r.armed && !done_r;
    head_cmd.ticks = ticks_r;
  end

  // Ring of slot cells; the head slot comes back to the tail updated.
  genvar gi;
  generate
    for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_ring
      slot_t cell_d;
      if (gi == SLOT_COUNT - 1) begin : g_tail
        assign cell_d = head_new;
      end else begin : g_mid
        assign cell_d = ring_q[gi+1];
      end
      mklp_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (step),
        .d     (cell_d),
        .q     (ring_q[gi])
      );
    end
  endgenerate

  mklp_head u_head (
    .cmd      (head_cmd),
    .slot_in  (ring_q[0]),
    .slot_out (head_new),
    .res      (head_res)
  );

  // Pending result: held until the next result or the end of the walk decides last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (step && head_res.valid) begin
      pend_valid_r <= 1'b1;
    end else if (flush_go) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && head_res.valid) begin
      pend_key_r  <= ring_q[0].key;
      pend_kind_r <= head_res.kind;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((step && head_res.valid && pend_valid_r) || (flush_go && pend_valid_r)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((step && head_res.valid && pend_valid_r) || (flush_go && pend_valid_r)) begin
      out_key_r  <= pend_key_r;
      out_kind_r <= pend_kind_r;
      out_last_r <= flush_go;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_key  = out_key_r;
  assign out_event_kind = out_kind_r;
  assign out_last       = out_last_r;

  // A new word is only taken with nothing left pending from the previous one.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("input ready while a result is still pending");

  // A full walk leads to the flush state.
  a_walk_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
    walk_end |=> (state_r == ST_FLUSH))
    else $error("walk did not end in flush");

  // A tick never claims a slot.
  a_tick_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (cmd_r.op == OP_TICK)) |-> !head_res.hit)
    else $error("tick word claimed a slot");

  // A key event hits at most one slot per walk.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done_r) |-> !head_res.hit)
    else $error("key event hit a second slot");

endmodule

>>> rtl/mklp_cell.sv
// One slot cell of the rotating key table.
module mklp_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  mklp_pkg::slot_t d,
  output mklp_pkg::slot_t q
);
  import mklp_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  // Take the neighbor's slot on every step of a walk.
  always_comb begin
    slot_nxt = shift ? d : slot_r;
  end

  // Reset frees the slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.key   <= '0;
      slot_r.phase <= PH_IDLE;
      slot_r.hold  <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign q = slot_r;

endmodule

>>> rtl/mklp_head.sv
// Update logic for the slot at the head of the rotating table.
module mklp_head (
  input  mklp_pkg::cmd_t     cmd,
  input  mklp_pkg::slot_t    slot_in,
  output mklp_pkg::slot_t    slot_out,
  output mklp_pkg::head_res_t res
);
  import mklp_pkg::*;

  logic [HOLD_BITS-1:0] hold_dec;
  logic [HOLD_BITS-1:0] reload;
  logic                 match;

  assign hold_dec = (slot_in.hold != '0) ? slot_in.hold - HOLD_BITS'(1) : '0;
  assign reload   = (cmd.ticks == '0) ? HOLD_BITS'(1) : cmd.ticks;
  // Occupied slots form a prefix, so the first free slot seen means no match exists.
  assign match    = cmd.armed && ((slot_in.key == cmd.code) || (slot_in.key == '0));

  always_comb begin
    slot_out  = slot_in;
    res.valid = 1'b0;
    res.kind  = KIND_SHORT;
    res.hit   = 1'b0;
    if (cmd.op == OP_TICK) begin
      // Count down a held key and fire the long press when it expires.
      if (slot_in.phase == PH_PRESSED) begin
        slot_out.hold = hold_dec;
        if (hold_dec == '0) begin
          slot_out.phase = PH_LONG;
          res.valid      = 1'b1;
          res.kind       = KIND_LONG;
        end
      end
    end else if (match) begin
      // Key event on the matching or newly given slot.
      res.hit      = 1'b1;
      slot_out.key = cmd.code;
      if (cmd.down) begin
        slot_out.phase = PH_PRESSED;
        slot_out.hold  = reload;
      end else begin
        res.valid      = (slot_in.phase == PH_PRESSED);
        res.kind       = KIND_SHORT;
        slot_out.phase = PH_IDLE;
        slot_out.hold  = '0;
      end
    end
  end

endmodule
